>>> hw/rtl/asfb_pkg.sv
// ----------------------------------------------------------------------------
// asfb_pkg
// Shared types and codes for the audio sample to float converter.
// ----------------------------------------------------------------------------
`default_nettype none

package asfb_pkg;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_S8   = 3'd1,
        FMT_S16  = 3'd2,
        FMT_S24  = 3'd3,
        FMT_S32  = 3'd4,
        FMT_F32  = 3'd5,
        FMT_F64  = 3'd6
    } t_fmt;

    localparam logic [1:0] CFG_FORMAT   = 2'd0;
    localparam logic [1:0] CFG_CHANNELS = 2'd1;
    localparam logic [1:0] CFG_FRAMES   = 2'd2;

    localparam logic [2:0]  RST_FORMAT   = 3'd0;
    localparam logic [3:0]  RST_CHANNELS = 4'd2;
    localparam logic [15:0] RST_FRAMES   = 16'd4410;

    typedef struct packed {
        logic [2:0] chan;
        logic       frame_last;
        logic       block_last;
    } t_pos;

endpackage

`default_nettype wire

>>> hw/rtl/asfb_smp_if.sv
// ----------------------------------------------------------------------------
// asfb_smp_if
// Raw sample channel: one right-aligned native sample per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface asfb_smp_if;
    logic        valid;
    logic        ready;
    logic [63:0] sample_bits;

    modport source (output valid, output sample_bits, input ready);
    modport sink   (input valid, input sample_bits, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/asfb_flt_if.sv
// ----------------------------------------------------------------------------
// asfb_flt_if
// Converted sample channel: float32 pattern plus frame and block marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface asfb_flt_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_float;
    logic [2:0]  channel_index;
    logic        frame_last;
    logic        block_last;

    modport source (output valid, output sample_float, output channel_index,
                    output frame_last, output block_last, input ready);
    modport sink   (input valid, input sample_float, input channel_index,
                    input frame_last, input block_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/asfb_seq.sv
// ----------------------------------------------------------------------------
// asfb_seq
// Channel and frame position counters; tags each sample with its marks.
// ----------------------------------------------------------------------------
`default_nettype none

module asfb_seq #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic [3:0]    i_chans,
    input  wire logic [15:0]   i_frames,
    output asfb_pkg::t_pos     o_pos
);

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [CW-1:0] r_chan, n_chan;
    logic [15:0]   r_frame, n_frame;
    logic [6:0]    eff_ch;
    logic [16:0]   eff_fr;
    logic          chan_last;
    logic          fr_last;

    always_comb begin
        if (i_chans == 4'd0) begin
            eff_ch = 7'd1;
        end else if (7'(i_chans) > 7'(MAX_CHANNELS)) begin
            eff_ch = 7'(MAX_CHANNELS);
        end else begin
            eff_ch = 7'(i_chans);
        end
        eff_fr = (i_frames == 16'd0) ? 17'd1 : 17'(i_frames);
        chan_last = (7'(r_chan) + 7'd1) >= eff_ch;
        fr_last   = (17'(r_frame) + 17'd1) >= eff_fr;
    end

    always_comb begin
        o_pos.chan       = 3'(r_chan);
        o_pos.frame_last = chan_last;
        o_pos.block_last = chan_last & fr_last;
    end

    always_comb begin
        n_chan  = r_chan;
        n_frame = r_frame;
        if (i_adv) begin
            if (chan_last) begin
                n_chan  = '0;
                n_frame = fr_last ? 16'd0 : r_frame + 16'd1;
            end else begin
                n_chan = r_chan + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= '0;
            r_frame <= '0;
        end else begin
            r_chan  <= n_chan;
            r_frame <= n_frame;
        end
    end

    a_block_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pos.block_last |-> o_pos.frame_last)
        else $error("block end without frame end");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_chan) < MAX_CHANNELS)
        else $error("channel position out of range");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_pos.frame_last) |=> (r_chan == '0))
        else $error("channel position did not wrap at frame end");

endmodule

`default_nettype wire

>>> hw/rtl/asfb_core.sv
// ----------------------------------------------------------------------------
// asfb_core
// Five-stage conversion pipeline: input, magnitude + 0.5, normalize,
// multiply by scale, round into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module asfb_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [2:0]  i_fmt,
    input  asfb_pkg::t_pos   i_pos,
    output logic             o_take,
    asfb_smp_if.sink         i_smp,
    asfb_flt_if.source       o_flt
);

    typedef struct packed {
        logic [5:0]  e;
        logic [23:0] m;
    } t_nf;

    // Round a 34-bit unsigned integer to 24 significant bits, nearest-even.
    function automatic t_nf norm_round(input logic [33:0] x);
        logic [5:0]  p;
        logic [5:0]  sh;
        logic [33:0] sx;
        logic        g;
        logic        st;
        logic [24:0] mr;
        t_nf         r;
        p = '0;
        for (int i = 0; i < 34; i++) begin
            if (x[i]) p = 6'(i);
        end
        if (p <= 6'd23) begin
            sx  = x << (6'd23 - p);
            r.m = sx[23:0];
            r.e = p;
        end else begin
            sh = p - 6'd23;
            sx = x >> sh;
            g  = x[sh - 6'd1];
            st = |(x & ((34'd1 << (sh - 6'd1)) - 34'd1));
            mr = {1'b0, sx[23:0]} + 25'(g & (st | sx[0]));
            if (mr[24]) begin
                r.m = 24'h800000;
                r.e = p + 6'd1;
            end else begin
                r.m = mr[23:0];
                r.e = p;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] cvt_f64(input logic [63:0] raw);
        logic        sgn;
        logic [62:0] mag;
        logic [10:0] de;
        logic [63:0] mw;
        logic [6:0]  sh;
        logic [63:0] q;
        logic        g;
        logic        st;
        logic [31:0] r;
        sgn = raw[63];
        mag = raw[62:0];
        de  = raw[62:52];
        mw  = {11'd0, 1'b1, raw[51:0]};
        if (mag > 63'h7FF0000000000000) begin
            r = {sgn, 8'hFF, 1'b1, mag[50:29]};
        end else if (mag >= 63'h47EFFFFFE0000000) begin
            r = {sgn, 8'hFF, 23'd0};
        end else if (de == 11'd0) begin
            r = {sgn, 31'd0};
        end else if (de >= 11'd897) begin
            g  = mw[28];
            st = |mw[27:0];
            r  = {sgn, 8'(de - 11'd896), mw[51:29]} + 32'(g & (st | mw[29]));
        end else begin
            // subnormal result: align to units of 2^-149
            sh = (de < 11'd863) ? 7'd63 : 7'(11'd926 - de);
            q  = mw >> sh;
            g  = mw[6'(sh - 7'd1)];
            st = |(mw & ((64'd1 << (sh - 7'd1)) - 64'd1));
            r  = {sgn, 8'd0, q[22:0]} + 32'(g & (st | q[0]));
        end
        return r;
    endfunction

    logic ce;
    logic fmt_ok;

    // stage 1: input register
    logic              r1_vld;
    asfb_pkg::t_fmt    r1_fmt;
    logic [63:0]       r1_raw;
    asfb_pkg::t_pos    r1_pos;
    // stage 2
    logic              r2_vld;
    logic              r2_flt_sel;
    logic [1:0]        r2_isz;
    logic              r2_neg;
    logic [33:0]       r2_h;
    logic [31:0]       r2_flt;
    asfb_pkg::t_pos    r2_pos;
    // stage 3
    logic              r3_vld;
    logic              r3_flt_sel;
    logic [1:0]        r3_isz;
    logic              r3_neg;
    t_nf               r3_g;
    logic [31:0]       r3_flt;
    asfb_pkg::t_pos    r3_pos;
    // stage 4
    logic              r4_vld;
    logic              r4_flt_sel;
    logic              r4_neg;
    logic [47:0]       r4_p;
    logic [8:0]        r4_ex;
    logic [31:0]       r4_flt;
    asfb_pkg::t_pos    r4_pos;
    // stage 5: output register
    logic              r5_vld;
    logic [31:0]       r5_res;
    asfb_pkg::t_pos    r5_pos;

    logic [31:0] vs;
    logic [32:0] vx;
    logic [32:0] a;
    t_nf         fa_nf;
    logic [33:0] fa;
    logic [33:0] n_h;
    logic [31:0] n_flt;
    logic [1:0]  n_isz;
    logic [23:0] sc_man;
    logic [8:0]  sc_sh;
    logic        p47;
    logic [22:0] mant;
    logic        rg;
    logic        rst_bit;
    logic [8:0]  exf;
    logic [31:0] n_res;

    assign ce      = !r5_vld || o_flt.ready;
    assign fmt_ok  = (i_fmt != asfb_pkg::FMT_NONE) && (i_fmt <= asfb_pkg::FMT_F64);
    assign i_smp.ready = ce;
    assign o_take  = i_smp.valid && ce && fmt_ok;

    // stage 2 logic: sign-extend, |v| rounded to float, then +/- 0.5 in half units
    always_comb begin
        case (r1_fmt)
            asfb_pkg::FMT_S8:  vs = {{24{r1_raw[7]}}, r1_raw[7:0]};
            asfb_pkg::FMT_S16: vs = {{16{r1_raw[15]}}, r1_raw[15:0]};
            asfb_pkg::FMT_S24: vs = {{8{r1_raw[23]}}, r1_raw[23:0]};
            default:           vs = r1_raw[31:0];
        endcase
        case (r1_fmt)
            asfb_pkg::FMT_S8:  n_isz = 2'd0;
            asfb_pkg::FMT_S16: n_isz = 2'd1;
            asfb_pkg::FMT_S24: n_isz = 2'd2;
            default:           n_isz = 2'd3;
        endcase
        vx    = {vs[31], vs};
        a     = vs[31] ? (~vx + 33'd1) : vx;
        fa_nf = norm_round({1'b0, a});
        if (fa_nf.e >= 6'd23) begin
            fa = 34'(fa_nf.m) << (fa_nf.e - 6'd23);
        end else begin
            fa = 34'(fa_nf.m) >> (6'd23 - fa_nf.e);
        end
        n_h   = vs[31] ? ((fa << 1) - 34'd1) : ((fa << 1) + 34'd1);
        n_flt = (r1_fmt == asfb_pkg::FMT_F64) ? cvt_f64(r1_raw) : r1_raw[31:0];
    end

    // scale = float32(1 / (2^(n-1) - 0.5)), mantissa and power-of-two shift
    always_comb begin
        unique case (r3_isz)
            2'd0:    begin sc_man = 24'h808081; sc_sh = 9'd7;  end
            2'd1:    begin sc_man = 24'h800080; sc_sh = 9'd15; end
            2'd2:    begin sc_man = 24'h800001; sc_sh = 9'd23; end
            default: begin sc_man = 24'h800000; sc_sh = 9'd31; end
        endcase
    end

    // stage 5 logic: round the product to nearest-even
    always_comb begin
        p47     = r4_p[47];
        mant    = p47 ? r4_p[46:24] : r4_p[45:23];
        rg      = p47 ? r4_p[23] : r4_p[22];
        rst_bit = p47 ? (|r4_p[22:0]) : (|r4_p[21:0]);
        exf     = r4_ex + 9'(p47);
        n_res   = {r4_neg, exf[7:0], mant} + 32'(rg & (rst_bit | mant[0]));
        if (r4_flt_sel) begin
            n_res = r4_flt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (ce) begin
            r1_vld <= o_take;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_fmt     <= asfb_pkg::t_fmt'(i_fmt);
            r1_raw     <= i_smp.sample_bits;
            r1_pos     <= i_pos;

            r2_flt_sel <= (r1_fmt == asfb_pkg::FMT_F32) || (r1_fmt == asfb_pkg::FMT_F64);
            r2_isz     <= n_isz;
            r2_neg     <= vs[31];
            r2_h       <= n_h;
            r2_flt     <= n_flt;
            r2_pos     <= r1_pos;

            r3_flt_sel <= r2_flt_sel;
            r3_isz     <= r2_isz;
            r3_neg     <= r2_neg;
            r3_g       <= norm_round(r2_h);
            r3_flt     <= r2_flt;
            r3_pos     <= r2_pos;

            r4_flt_sel <= r3_flt_sel;
            r4_neg     <= r3_neg;
            r4_p       <= r3_g.m * sc_man;
            r4_ex      <= 9'(r3_g.e) + 9'd126 - sc_sh;
            r4_flt     <= r3_flt;
            r4_pos     <= r3_pos;

            r5_res     <= n_res;
            r5_pos     <= r4_pos;
        end
    end

    assign o_flt.valid         = r5_vld;
    assign o_flt.sample_float  = r5_res;
    assign o_flt.channel_index = r5_pos.chan;
    assign o_flt.frame_last    = r5_pos.frame_last;
    assign o_flt.block_last    = r5_pos.block_last;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r5_vld && !o_flt.ready) |=> (r5_vld && $stable(r5_res)))
        else $error("result lost while stalled");

    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (!r5_vld || o_flt.ready))
        else $error("sample taken while pipeline stalled");

    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r5_vld && r5_pos.block_last) |-> r5_pos.frame_last)
        else $error("block mark without frame mark");

endmodule

`default_nettype wire

>>> hw/rtl/audio_sample_to_float_blocker.sv
// ----------------------------------------------------------------------------
// audio_sample_to_float_blocker
// Converts interleaved native audio samples to float32 and marks frame and
// block ends.
//
//   port     dir  protocol      word
//   i_smp    in   valid/ready   sample_bits[63:0]
//   o_flt    out  valid/ready   sample_float, channel_index, frame/block marks
//   i_cfg_*  in   write strobe  index 0 format, 1 channels, 2 frames per block
//
// One sample per cycle while o_flt is not stalled; an accepted word passes
// through every stage in order and is then offered on o_flt from the output register.
// All five stages share one pipeline enable, so a stalled output holds every
// stage and drops i_smp.ready.
// Samples taken with format none or code 7 give no result and leave the
// counters where they are.
// Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_sample_to_float_blocker #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    asfb_smp_if.sink         i_smp,
    asfb_flt_if.source       o_flt
);

    logic [2:0]     r_fmt;
    logic [3:0]     r_chans;
    logic [15:0]    r_frames;
    logic           take;
    asfb_pkg::t_pos pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= asfb_pkg::RST_FORMAT;
            r_chans  <= asfb_pkg::RST_CHANNELS;
            r_frames <= asfb_pkg::RST_FRAMES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                asfb_pkg::CFG_FORMAT:   r_fmt    <= i_cfg_data[2:0];
                asfb_pkg::CFG_CHANNELS: r_chans  <= i_cfg_data[3:0];
                asfb_pkg::CFG_FRAMES:   r_frames <= i_cfg_data;
                default: ;
            endcase
        end
    end

    asfb_seq #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (take),
        .i_chans  (r_chans),
        .i_frames (r_frames),
        .o_pos    (pos)
    );

    asfb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fmt   (r_fmt),
        .i_pos   (pos),
        .o_take  (take),
        .i_smp   (i_smp),
        .o_flt   (o_flt)
    );

endmodule

`default_nettype wire
